// ----- design/hbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_pkg
// shared types, codes and default table for the host bridge config space
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int CFG_DEPTH = 256;
    localparam int OFF_W     = 8;
    localparam int NUM_PAM   = 7;

    typedef enum logic [1:0] {
        REQ_READ      = 2'd0,
        REQ_WRITE     = 2'd1,
        REQ_BUS_RESET = 2'd2,
        REQ_LOAD      = 2'd3
    } req_t;

    localparam logic [7:0]  OFF_CMD_LO   = 8'h04;
    localparam logic [7:0]  OFF_CMD_HI   = 8'h05;
    localparam logic [7:0]  OFF_STS_LO   = 8'h06;
    localparam logic [7:0]  OFF_STS_HI   = 8'h07;
    localparam logic [7:0]  OFF_PAM0     = 8'h59;
    localparam logic [7:0]  OFF_PAM6     = 8'h5f;
    localparam logic [7:0]  OFF_SMRAM    = 8'h72;
    localparam logic [7:0]  SMRAM_RESET  = 8'h02;
    localparam logic [7:0]  SMRAM_MASK   = 8'h48;

    localparam logic [19:0] BIOS_BASE    = 20'hf0000;
    localparam logic [17:0] BIOS_SIZE    = 18'h10000;
    localparam logic [19:0] EXT_BASE     = 20'hc0000;
    localparam logic [17:0] SEG_SIZE     = 18'h04000;
    localparam int          SEG_SHIFT    = 15;
    localparam logic [19:0] SMRAM_BASE   = 20'ha0000;
    localparam logic [17:0] SMRAM_SIZE   = 18'h20000;

    typedef struct packed {
        logic [19:0] base;
        logic [17:0] size;
        logic [1:0]  st;
    } ev_t;

    typedef struct packed {
        req_t        req;
        logic        fn_zero;
        logic [7:0]  offset;
        logic        use_flop;
        logic [7:0]  flop_byte;
        logic        vld;
        logic        defvar;
        ev_t         ev0;
        ev_t         ev1;
        logic        any_ev;
        logic        two_ev;
        logic        shadow;
    } stage_t;

    function automatic logic [7:0] default_byte(input logic variant, input logic [7:0] off);
        logic [7:0] b;
        b = 8'h00;
        case (off)
            8'h00: b = 8'h86;
            8'h01: b = 8'h80;
            8'h02: b = 8'h2d;
            8'h03: b = 8'h16;
            8'h04: b = 8'h06;
            8'h07: b = variant ? 8'h02 : 8'h82;
            8'h0b: b = 8'h06;
            8'h52: b = variant ? 8'h42 : 8'h40;
            8'h53: b = variant ? 8'h14 : 8'h00;
            8'h56: b = variant ? 8'h52 : 8'h00;
            8'h57: b = 8'h01;
            8'h60: b = 8'h02;
            8'h61: b = 8'h02;
            8'h62: b = 8'h02;
            8'h63: b = 8'h02;
            8'h64: b = 8'h02;
            8'h67: b = variant ? 8'h11 : 8'h00;
            8'h69: b = variant ? 8'h03 : 8'h00;
            8'h70: b = variant ? 8'h20 : 8'h00;
            8'h72: b = 8'h02;
            8'h74: b = variant ? 8'h0e : 8'h00;
            8'h78: b = variant ? 8'h23 : 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- design/hbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/host_bridge_config_space_pam.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// host_bridge_config_space_pam
// 256-byte host bridge configuration space with pam shadow and smram control
// ----------------------------------------------------------------------------
// an accepted transaction is registered in the s1 stage, then its first result in the output register
// throughput: 1 transaction per cycle unless m_tready stalls; a write or bus reset
//   with two map events stalls input; the output register sends one result per cycle
// reset: pipeline empty, board variant 0, per-byte valid flags cleared so
//   every byte reads its default table value, shadow flag cleared
// ----------------------------------------------------------------------------
module host_bridge_config_space_pam (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // func_num, reg_offset, wr_data, zero fill
    input  wire logic [1:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // rd_data, map_base, map_size, read_internal,
                                        // write_internal, shadow_bios, zero fill
    output logic             m_tuser,   // map_valid
    output logic             m_tlast
);

    // read-only offsets
    localparam logic [7:0] OFF_ID_FIRST    = 8'h00;
    localparam logic [7:0] OFF_ID_LAST     = 8'h03;
    localparam logic [7:0] OFF_CLASS_FIRST = 8'h08;
    localparam logic [7:0] OFF_CLASS_LAST  = 8'h0c;
    localparam logic [7:0] OFF_BIST        = 8'h0e;
    localparam logic [7:0] OFF_DEV_FIRST   = 8'h10;
    localparam logic [7:0] OFF_DEV_LAST    = 8'h4e;

    // input fields
    hbp_pkg::req_t in_req;
    logic [2:0]    in_fn;
    logic [7:0]    in_off;
    logic [7:0]    in_wd;
    logic          s_accept;

    assign in_req   = hbp_pkg::req_t'(s_tuser);
    assign in_fn    = s_tdata[2:0];
    assign in_off   = s_tdata[10:3];
    assign in_wd    = s_tdata[18:11];
    assign s_accept = s_tvalid && s_tready;

    // state
    logic                                variant_reg;
    logic                                defvar_reg, defvar_next;
    logic                                shadow_reg, shadow_next;
    logic [7:0]                          pam_reg [hbp_pkg::NUM_PAM];
    logic [7:0]                          pam_next [hbp_pkg::NUM_PAM];
    logic [7:0]                          smram_reg, smram_next;
    logic [hbp_pkg::CFG_DEPTH-1:0]       vld_reg, vld_next;

    logic                                s1_valid_reg;
    hbp_pkg::stage_t                     s1_reg, s1_next;
    logic                                phase_reg;

    logic                                out_valid_reg;
    logic [7:0]                          out_rd_reg;
    logic                                out_map_reg;
    hbp_pkg::ev_t                        out_ev_reg;
    logic                                out_shadow_reg;
    logic                                out_last_reg;

    // ram
    logic                                ram_we;
    logic [7:0]                          ram_wdata;
    logic [7:0]                          ram_q;

    hbp_ram #(
        .WIDTH (8),
        .DEPTH (hbp_pkg::CFG_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_off),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (in_off),
        .rdata (ram_q)
    );

    // transaction decode and state update
    logic [7:0]   wv;
    logic [7:0]   old_b;
    logic [7:0]   diff;
    logic [2:0]   pidx;
    logic [2:0]   seg;
    logic [19:0]  seg_base;
    logic         lo_ch, hi_ch;
    hbp_pkg::ev_t lo_ev, hi_ev;
    logic         ev_a, ev_b;

    always_comb
    begin
        defvar_next = defvar_reg;
        shadow_next = shadow_reg;
        pam_next    = pam_reg;
        smram_next  = smram_reg;
        vld_next    = vld_reg;
        ram_we      = 1'b0;
        s1_next     = '0;
        lo_ch       = 1'b0;
        hi_ch       = 1'b0;
        ev_a        = 1'b0;
        ev_b        = 1'b0;
        lo_ev       = '0;
        hi_ev       = '0;
        pidx        = in_off[2:0] - 3'd1;
        seg         = pidx - 3'd1;
        seg_base    = hbp_pkg::EXT_BASE + (20'(seg) << hbp_pkg::SEG_SHIFT);
        old_b       = 8'h00;
        wv          = in_wd;

        case (in_off)
            hbp_pkg::OFF_CMD_LO: wv = (in_wd & 8'h02) | 8'h04;
            hbp_pkg::OFF_CMD_HI,
            hbp_pkg::OFF_STS_LO: wv = 8'h00;
            hbp_pkg::OFF_STS_HI: wv = 8'h02;
            default:             wv = in_wd;
        endcase
        ram_wdata = wv;

        if (in_off inside {[hbp_pkg::OFF_PAM0:hbp_pkg::OFF_PAM6]})
        begin
            old_b = pam_reg[pidx];
        end
        else if (in_off == hbp_pkg::OFF_SMRAM)
        begin
            old_b = smram_reg;
        end
        diff = old_b ^ wv;

        s1_next.req       = in_req;
        s1_next.fn_zero   = (in_fn == 3'd0);
        s1_next.offset    = in_off;
        s1_next.use_flop  = (in_off inside {[hbp_pkg::OFF_PAM0:hbp_pkg::OFF_PAM6]})
                            || (in_off == hbp_pkg::OFF_SMRAM);
        s1_next.flop_byte = old_b;
        s1_next.vld       = vld_reg[in_off];
        s1_next.defvar    = defvar_reg;

        case (in_req)
            hbp_pkg::REQ_WRITE:
            begin
                if (in_fn == 3'd0 && !(in_off inside {[OFF_ID_FIRST:OFF_ID_LAST],
                                                      [OFF_CLASS_FIRST:OFF_CLASS_LAST],
                                                      OFF_BIST,
                                                      [OFF_DEV_FIRST:OFF_DEV_LAST]}))
                begin
                    if (in_off == hbp_pkg::OFF_PAM0)
                    begin
                        pam_next[0] = wv;
                        if (diff[7:4] != 4'h0)
                        begin
                            ev_a        = 1'b1;
                            lo_ev       = '{hbp_pkg::BIOS_BASE, hbp_pkg::BIOS_SIZE, wv[5:4]};
                            shadow_next = wv[4];
                        end
                    end
                    else if (in_off inside {[hbp_pkg::OFF_PAM0 + 8'd1:hbp_pkg::OFF_PAM6]})
                    begin
                        pam_next[pidx] = wv;
                        lo_ch = (diff[3:0] != 4'h0);
                        hi_ch = (diff[7:4] != 4'h0);
                        lo_ev = '{seg_base, hbp_pkg::SEG_SIZE, wv[1:0]};
                        hi_ev = '{seg_base + 20'(hbp_pkg::SEG_SIZE), hbp_pkg::SEG_SIZE,
                                  wv[5:4]};
                        ev_a  = lo_ch || hi_ch;
                        ev_b  = lo_ch && hi_ch;
                        if (!lo_ch)
                        begin
                            lo_ev = hi_ev;
                        end
                    end
                    else if (in_off == hbp_pkg::OFF_SMRAM)
                    begin
                        smram_next = wv;
                        if ((diff & hbp_pkg::SMRAM_MASK) != 8'h00)
                        begin
                            ev_a  = 1'b1;
                            lo_ev = '{hbp_pkg::SMRAM_BASE, hbp_pkg::SMRAM_SIZE,
                                      ((wv & hbp_pkg::SMRAM_MASK) == hbp_pkg::SMRAM_MASK)
                                      ? 2'd3 : 2'd0};
                        end
                    end
                    else
                    begin
                        ram_we           = s_accept;
                        vld_next[in_off] = 1'b1;
                    end
                end
            end
            hbp_pkg::REQ_BUS_RESET:
            begin
                pam_next[0] = 8'h00;
                smram_next  = hbp_pkg::SMRAM_RESET;
                lo_ev       = '{hbp_pkg::BIOS_BASE, hbp_pkg::BIOS_SIZE, 2'd0};
                hi_ev       = '{hbp_pkg::SMRAM_BASE, hbp_pkg::SMRAM_SIZE, 2'd0};
                lo_ch       = (pam_reg[0][7:4] != 4'h0);
                hi_ch       = ((smram_reg & hbp_pkg::SMRAM_MASK) != 8'h00);
                ev_a        = lo_ch || hi_ch;
                ev_b        = lo_ch && hi_ch;
                if (lo_ch)
                begin
                    shadow_next = 1'b0;
                end
                else
                begin
                    lo_ev = hi_ev;
                end
            end
            hbp_pkg::REQ_LOAD:
            begin
                for (int i = 0; i < hbp_pkg::NUM_PAM; i++)
                begin
                    pam_next[i] = 8'h00;
                end
                smram_next  = hbp_pkg::SMRAM_RESET;
                vld_next    = '0;
                defvar_next = variant_reg;
            end
            default:
            begin
            end
        endcase

        s1_next.ev0    = lo_ev;
        s1_next.ev1    = hi_ev;
        s1_next.any_ev = ev_a;
        s1_next.two_ev = ev_b;
        s1_next.shadow = shadow_next;
    end

    // output stage control
    logic         out_load;
    logic         s1_done;
    logic [7:0]   rd_val;
    hbp_pkg::ev_t ev_sel;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_done  = !s1_reg.two_ev || phase_reg;
    assign s_tready = !s1_valid_reg || (out_load && s1_done);

    always_comb
    begin
        rd_val = 8'h00;
        if (s1_reg.req == hbp_pkg::REQ_READ)
        begin
            if (!s1_reg.fn_zero)
            begin
                rd_val = 8'hff;
            end
            else if (s1_reg.use_flop)
            begin
                rd_val = s1_reg.flop_byte;
            end
            else if (s1_reg.vld)
            begin
                rd_val = ram_q;
            end
            else
            begin
                rd_val = hbp_pkg::default_byte(s1_reg.defvar, s1_reg.offset);
            end
        end
        ev_sel = phase_reg ? s1_reg.ev1 : s1_reg.ev0;
        if (!s1_reg.any_ev)
        begin
            ev_sel = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= 1'b0;
            defvar_reg    <= 1'b0;
            shadow_reg    <= 1'b0;
            smram_reg     <= hbp_pkg::SMRAM_RESET;
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < hbp_pkg::NUM_PAM; i++)
            begin
                pam_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                variant_reg <= cfg_wdata;
            end
            if (s_accept)
            begin
                defvar_reg <= defvar_next;
                shadow_reg <= shadow_next;
                pam_reg    <= pam_next;
                smram_reg  <= smram_next;
                vld_reg    <= vld_next;
            end

            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load && s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                phase_reg <= !s1_done;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_reg <= s1_next;
        end
        if (out_load)
        begin
            out_rd_reg     <= rd_val;
            out_map_reg    <= s1_reg.any_ev;
            out_ev_reg     <= ev_sel;
            out_shadow_reg <= s1_reg.shadow;
            out_last_reg   <= s1_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_map_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_shadow_reg, out_ev_reg.st[1], out_ev_reg.st[0],
                       out_ev_reg.size, out_ev_reg.base, out_rd_reg};

    // checks
    a_no_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[47:8] == 40'd0))
        else $error("map fields set on a result without a map event");

    a_map_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'h00))
        else $error("read data on a map event result");

    a_phase_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (s1_valid_reg && s1_reg.two_ev))
        else $error("second event phase without a two event transaction");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.two_ev && !phase_reg) |-> !s_tready)
        else $error("input taken while first of two events pending");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_req == hbp_pkg::REQ_LOAD) |=> (vld_reg == '0))
        else $error("valid flags not cleared by load defaults");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level bench for the host bridge config space: reads, writes, pam and
// smram map events, bus reset and default reload, predicted and compared
// result by result against a behavioral copy of the register space
// ----------------------------------------------------------------------------
module tb_top;

    import hbp_pkg::*;

    localparam int  CLK_HALF       = 2;
    localparam int  CYCLE_LIMIT    = 400000;
    localparam int  PHASE_ITEMS    = 375;
    localparam int  LONG_HOLD      = 300;
    localparam int  MAX_REPORTS    = 60;

    localparam logic [7:0] OFF_ID_LAST      = 8'h03;
    localparam logic [7:0] OFF_CLASS_FIRST  = 8'h08;
    localparam logic [7:0] OFF_CLASS_LAST   = 8'h0c;
    localparam logic [7:0] OFF_BIST         = 8'h0e;
    localparam logic [7:0] OFF_DEV_FIRST    = 8'h10;
    localparam logic [7:0] OFF_DEV_LAST     = 8'h4e;
    localparam logic [7:0] OFF_OPEN_FIRST   = 8'h4f;
    localparam logic [7:0] OFF_PAM1         = 8'h5a;
    localparam logic [7:0] OFF_TOP          = 8'hff;

    typedef struct packed {
        logic [7:0]  rd;
        logic        mapped;
        logic [19:0] base;
        logic [17:0] size;
        logic        rd_int;
        logic        wr_int;
        logic        shadow;
        logic        last;
    } map_result_t;

    class config_space_scoreboard;
        logic [7:0]  space [CFG_DEPTH];
        logic        shadow_flag;
        logic        variant;
        ev_t         events [$];
        map_result_t expected_q [$];
        int          errors;

        function void load_table();
            for (int i = 0; i < CFG_DEPTH; i++)
                space[i] = 8'h00;
            space[8'h00] = 8'h86;
            space[8'h01] = 8'h80;
            space[8'h02] = 8'h2d;
            space[8'h03] = 8'h16;
            space[OFF_CMD_LO] = 8'h06;
            space[OFF_STS_HI] = variant ? 8'h02 : 8'h82;
            space[8'h0b] = 8'h06;
            space[8'h52] = variant ? 8'h42 : 8'h40;
            space[8'h57] = 8'h01;
            for (int i = 8'h60; i <= 8'h64; i++)
                space[i] = 8'h02;
            space[OFF_SMRAM] = SMRAM_RESET;
            if (variant)
            begin
                space[8'h53] = 8'h14;
                space[8'h56] = 8'h52;
                space[8'h67] = 8'h11;
                space[8'h69] = 8'h03;
                space[8'h70] = 8'h20;
                space[8'h74] = 8'h0e;
                space[8'h78] = 8'h23;
            end
        endfunction

        function void power_on();
            variant     = 1'b0;
            shadow_flag = 1'b0;
            errors      = 0;
            load_table();
        endfunction

        function void add_event(logic [19:0] base, logic [17:0] size, logic [1:0] st);
            ev_t e;
            e.base = base;
            e.size = size;
            e.st   = st;
            if (events.size() < 2)
                events.push_back(e);
        endfunction

        function void store_byte(logic [2:0] fn, logic [7:0] off, logic [7:0] d);
            logic [7:0]  v;
            logic [7:0]  diff;
            logic [19:0] seg;
            v    = d;
            diff = space[off] ^ d;
            if (fn != 3'd0)
                return;
            if (off <= OFF_ID_LAST || (off >= OFF_CLASS_FIRST && off <= OFF_CLASS_LAST) ||
                off == OFF_BIST || (off >= OFF_DEV_FIRST && off <= OFF_DEV_LAST))
                return;
            if (off == OFF_CMD_LO)
                v = (d & 8'h02) | 8'h04;
            else if (off == OFF_CMD_HI || off == OFF_STS_LO)
                v = 8'h00;
            else if (off == OFF_STS_HI)
                v = 8'h02;
            else if (off == OFF_PAM0)
            begin
                if (diff[7:4] != 4'd0)
                begin
                    add_event(BIOS_BASE, BIOS_SIZE, v[5:4]);
                    shadow_flag = v[4];
                end
            end
            else if (off >= OFF_PAM1 && off <= OFF_PAM6)
            begin
                seg = EXT_BASE + ({12'd0, off - OFF_PAM1} << SEG_SHIFT);
                if (diff[3:0] != 4'd0)
                    add_event(seg, SEG_SIZE, v[1:0]);
                if (diff[7:4] != 4'd0)
                    add_event(seg + 20'(SEG_SIZE), SEG_SIZE, v[5:4]);
            end
            else if (off == OFF_SMRAM)
            begin
                if ((diff & SMRAM_MASK) != 8'h00)
                    add_event(SMRAM_BASE, SMRAM_SIZE,
                              ((v & SMRAM_MASK) == SMRAM_MASK) ? 2'b11 : 2'b00);
            end
            space[off] = v;
        endfunction

        function void note_input(req_t req, logic [2:0] fn, logic [7:0] off, logic [7:0] d);
            logic [7:0]  rd;
            int          n;
            map_result_t r;
            rd = 8'h00;
            events.delete();
            case (req)
                REQ_READ:      rd = (fn != 3'd0) ? 8'hff : space[off];
                REQ_WRITE:     store_byte(fn, off, d);
                REQ_BUS_RESET:
                begin
                    store_byte(3'd0, OFF_PAM0, 8'h00);
                    store_byte(3'd0, OFF_SMRAM, SMRAM_RESET);
                end
                default:       load_table();
            endcase
            n = (events.size() > 0) ? events.size() : 1;
            for (int k = 0; k < n; k++)
            begin
                r        = '0;
                r.rd     = rd;
                r.shadow = shadow_flag;
                r.last   = (k == n - 1);
                if (k < events.size())
                begin
                    r.mapped = 1'b1;
                    r.base   = events[k].base;
                    r.size   = events[k].size;
                    r.rd_int = events[k].st[0];
                    r.wr_int = events[k].st[1];
                end
                expected_q.push_back(r);
            end
        endfunction

        function void report(string msg);
            if (errors < MAX_REPORTS)
                $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void check_result(logic [55:0] td, logic tu, logic tl);
            map_result_t e;
            if (expected_q.size() == 0)
            begin
                report("result with nothing outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (td[7:0] !== e.rd)
                report($sformatf("rd_data got %h exp %h", td[7:0], e.rd));
            if (tu !== e.mapped)
                report($sformatf("map_valid got %b exp %b", tu, e.mapped));
            if (td[27:8] !== e.base)
                report($sformatf("map_base got %h exp %h", td[27:8], e.base));
            if (td[45:28] !== e.size)
                report($sformatf("map_size got %h exp %h", td[45:28], e.size));
            if (td[46] !== e.rd_int)
                report($sformatf("read_internal got %b exp %b", td[46], e.rd_int));
            if (td[47] !== e.wr_int)
                report($sformatf("write_internal got %b exp %b", td[47], e.wr_int));
            if (td[48] !== e.shadow)
                report($sformatf("shadow_bios got %b exp %b", td[48], e.shadow));
            if (tl !== e.last)
                report($sformatf("last got %b exp %b", tl, e.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    config_space_scoreboard sb;
    bit          idle_en;
    bit          hold_req;
    int          cycles;

    host_bridge_config_space_pam DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(req_t req, logic [2:0] fn, logic [7:0] off, logic [7:0] d);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {5'd0, d, off, fn};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(req, fn, off, d);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_variant(logic v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.variant = v;
    endtask

    task automatic random_item();
        int         r;
        int         pick;
        req_t       req;
        logic [2:0] fn;
        logic [7:0] off;
        r    = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        fn   = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        if (pick <= 3)
            off = 8'($urandom_range(OFF_PAM0, OFF_PAM6));
        else if (pick == 4)
            off = OFF_SMRAM;
        else if (pick == 5)
            off = 8'($urandom_range(0, 15));
        else
            off = 8'($urandom_range(0, 255));
        if (r < 40)
            req = REQ_READ;
        else if (r < 88)
            req = REQ_WRITE;
        else if (r < 94)
            req = REQ_BUS_RESET;
        else
            req = REQ_LOAD;
        send_item(req, fn, off, 8'($urandom_range(0, 255)));
    endtask

    task automatic directed_items();
        send_item(REQ_READ,  3'd0, 8'h00, 8'h00);
        send_item(REQ_READ,  3'd7, OFF_ID_LAST, 8'h00);
        send_item(REQ_WRITE, 3'd0, 8'h00, 8'hff);
        send_item(REQ_WRITE, 3'd0, OFF_BIST, 8'hff);
        send_item(REQ_WRITE, 3'd0, OFF_CMD_LO, 8'hff);
        send_item(REQ_READ,  3'd0, OFF_CMD_LO, 8'h00);
        send_item(REQ_WRITE, 3'd0, OFF_CMD_HI, 8'hff);
        send_item(REQ_WRITE, 3'd0, OFF_STS_HI, 8'h00);
        send_item(REQ_WRITE, 3'd0, OFF_DEV_LAST, 8'h5a);
        send_item(REQ_WRITE, 3'd0, OFF_OPEN_FIRST, 8'hff);
        // shadow bios on, then a low-nibble-only change with no event
        send_item(REQ_WRITE, 3'd0, OFF_PAM0, 8'h30);
        send_item(REQ_WRITE, 3'd0, OFF_PAM0, 8'h3f);
        // both nibbles change: two events
        send_item(REQ_WRITE, 3'd0, OFF_PAM6, 8'hff);
        send_item(REQ_WRITE, 3'd0, OFF_PAM1, 8'h21);
        send_item(REQ_WRITE, 3'd0, OFF_PAM1, 8'h21);
        send_item(REQ_WRITE, 3'd0, OFF_SMRAM, 8'h48);
        send_item(REQ_WRITE, 3'd0, OFF_SMRAM, 8'h0a);
        send_item(REQ_WRITE, 3'd5, OFF_PAM0, 8'h00);
        send_item(REQ_BUS_RESET, 3'd0, 8'h00, 8'h00);
        send_item(REQ_READ,  3'd0, OFF_PAM6, 8'h00);
        send_item(REQ_LOAD,  3'd0, 8'h00, 8'h00);
        send_item(REQ_READ,  3'd0, OFF_PAM6, 8'h00);
        send_item(REQ_WRITE, 3'd0, OFF_TOP, 8'hff);
        send_item(REQ_READ,  3'd0, OFF_TOP, 8'h00);
        send_item(REQ_READ,  3'd0, OFF_SMRAM, 8'h00);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_READ;
        idle_en   = 1'b0;
        hold_req  = 1'b0;
        cycles    = 0;
        sb = new();
        sb.power_on();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        write_variant(1'b0);
        idle_en = 1'b1;
        directed_items();

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            write_variant(phase[0] ? 1'b0 : 1'b1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 50 == 0)
                    idle_en = (phase != 3) && ($urandom_range(0, 3) != 0);
                if (phase == 1 && i == 60)
                    hold_req = 1'b1;
                random_item();
            end
        end

        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
design/hbp_pkg.sv
design/hbp_ram.sv
design/host_bridge_config_space_pam.sv
bench/tb_top.sv
